>>> src/imu_rfc_pkg.sv
// imu_rfc_pkg: shared types and constants for the IMU response frame checker.
// No dependencies; imported by every module of the block.
package imu_rfc_pkg;

   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 5;
   localparam int WORD_W  = 16;
   localparam int INDEX_W = 4;

   // shortest frame that carries a checksum: header plus two checksum bytes
   localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(3);

   localparam logic KIND_WORD    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [WORD_W-1:0]  word_value;
      logic [INDEX_W-1:0] word_index;
      logic [BYTE_W-1:0]  header_value;
      logic               checksum_ok;
      logic               last;
   } rsp_type;

endpackage

>>> src/imu_response_frame_checker.sv
// imu_response_frame_checker: top level of the IMU response frame checker.
// Depends on imu_rfc_pkg, imu_rfc_frame and imu_rfc_out.
//
//   channel | direction | ports                                   | per request
//   req     | in        | req_data_byte, req_frame_length         | one frame byte
//   rsp     | out       | rsp_kind, rsp_word_value, rsp_word_index,| data word or
//           |           | rsp_header_value, rsp_checksum_ok,      | frame verdict
//           |           | rsp_last                                |
//
// One request per cycle; its result, if any, is valid the next cycle.
// Rate is set by the single result register: req_ready drops only while a
// result is held and rsp_ready is low.
// Synchronous reset returns the checker to awaiting a header byte.
module imu_response_frame_checker
   import imu_rfc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 23
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic [LEN_W-1:0]   req_frame_length,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [WORD_W-1:0]  rsp_word_value,
   output logic [INDEX_W-1:0] rsp_word_index,
   output logic [BYTE_W-1:0]  rsp_header_value,
   output logic               rsp_checksum_ok,
   output logic               rsp_last
);

   logic    step;
   logic    res_valid;
   rsp_type res;
   rsp_type rsp_data;

   assign step = req_valid && req_ready;

   imu_rfc_frame #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .data_byte   (req_data_byte),
      .frame_length(req_frame_length),
      .res_valid   (res_valid),
      .res         (res)
   );

   imu_rfc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (step && res_valid),
      .load_data (res),
      .load_ready(req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_word_value   = rsp_data.word_value;
   assign rsp_word_index   = rsp_data.word_index;
   assign rsp_header_value = rsp_data.header_value;
   assign rsp_checksum_ok  = rsp_data.checksum_ok;
   assign rsp_last         = rsp_data.last;

endmodule

>>> src/imu_rfc_frame.sv
// imu_rfc_frame: frame position tracking, word assembly and checksum compare.
// Depends on imu_rfc_pkg; produces at most one result per accepted byte.
module imu_rfc_frame
   import imu_rfc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 23
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [LEN_W-1:0]  frame_length,
   output logic              res_valid,
   output rsp_type           res
);

   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [WORD_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  held_ff, held_in;
   logic [BYTE_W-1:0]  hdr_ff, hdr_in;
   logic [INDEX_W-1:0] wc_ff, wc_in;

   logic [LEN_W:0]    pos_ext, len_ext;
   logic [WORD_W-1:0] assembled;
   logic              len_valid;

   assign pos_ext   = {1'b0, pos_ff};
   assign len_ext   = {1'b0, len_ff};
   assign assembled = {held_ff, data_byte};
   assign len_valid = (len_ff >= LEN_MIN) && (len_ext <= (LEN_W+1)'(MAX_FRAME_BYTES))
                      && len_ff[0];

   always_comb begin
      pos_in    = pos_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      held_in   = held_ff;
      hdr_in    = hdr_ff;
      wc_in     = wc_ff;
      res_valid = 1'b0;
      res.kind         = KIND_WORD;
      res.word_value   = assembled;
      res.word_index   = wc_ff;
      res.header_value = hdr_ff;
      res.checksum_ok  = 1'b0;
      res.last         = 1'b0;
      if (pos_ff == '0) begin
         len_in  = frame_length;
         hdr_in  = data_byte;
         sum_in  = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
         held_in = '0;
         wc_in   = '0;
         res.header_value = data_byte;
         if (frame_length < LEN_MIN) begin
            // header alone closes a too-short frame
            res_valid        = 1'b1;
            res.kind         = KIND_VERDICT;
            res.word_value   = '0;
            res.word_index   = '0;
            res.last         = 1'b1;
            pos_in           = '0;
         end else begin
            pos_in = LEN_W'(1);
         end
      end else if (pos_ext + (LEN_W+1)'(1) >= len_ext) begin
         res_valid       = 1'b1;
         res.kind        = KIND_VERDICT;
         res.checksum_ok = len_valid && (assembled == sum_ff);
         res.last        = 1'b1;
         pos_in          = '0;
      end else begin
         pos_in = pos_ff + LEN_W'(1);
         if (pos_ext + (LEN_W+1)'(2) == len_ext) begin
            held_in = data_byte;
         end else if (pos_ff[0]) begin
            held_in = data_byte;
         end else begin
            res_valid = 1'b1;
            sum_in    = sum_ff + assembled;
            wc_in     = wc_ff + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         len_ff  <= '0;
         sum_ff  <= '0;
         held_ff <= '0;
         hdr_ff  <= '0;
         wc_ff   <= '0;
      end else if (step) begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         sum_ff  <= sum_in;
         held_ff <= held_in;
         hdr_ff  <= hdr_in;
         wc_ff   <= wc_in;
      end
   end

endmodule

>>> src/imu_rfc_out.sv
// imu_rfc_out: result register between the frame logic and the rsp channel.
// Depends on imu_rfc_pkg; refills in the same cycle the held result leaves.
module imu_rfc_out
   import imu_rfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    load_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign load_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
